// ===== rtl/core/vector_angle_quantizer_defines.svh =====
// -----------------------------------------------------------------------------
// Vector angle quantizer assertion macros
// Shared assertion forms; each expects aclk and aresetn in the using module.
// -----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_QUANTIZER_DEFINES_SVH
`define VECTOR_ANGLE_QUANTIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VAQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VAQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/vaq_pkg.sv =====
// -----------------------------------------------------------------------------
// Vector angle quantizer package
// Widths, tag types and the CORDIC arctangent table, built at elaboration.
// -----------------------------------------------------------------------------
`default_nettype none

package vaq_pkg;

    // Coordinate and datapath widths.
    localparam int COORD_BITS   = 16;
    localparam int MAG_W        = COORD_BITS;
    localparam int MSB_W        = $clog2(COORD_BITS);
    localparam int ACC_W        = 64;
    localparam int SH_W         = 6;
    localparam int NORM_MSB     = 59;
    localparam int CORDIC_ITERS = 62;
    localparam int CODE_W       = 16;
    localparam int ABITS_W      = 5;
    localparam int OBYTES_W     = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_BYTES = 2'd1;
    localparam logic [OBYTES_W-1:0]  OBYTES_ONE       = 2'd1;
    localparam logic [OBYTES_W-1:0]  OBYTES_RESET     = 2'd2;

    // Angles are unsigned Q0.64 fractions of a full turn.
    localparam logic [ACC_W-1:0] TURN_HALF    = 64'h8000_0000_0000_0000;
    localparam logic [ACC_W-1:0] TURN_QUARTER = 64'h4000_0000_0000_0000;
    localparam logic [ACC_W-1:0] TURN_EIGHTH  = 64'h2000_0000_0000_0000;
    localparam logic [ACC_W-1:0] Q61_ONE      = 64'h2000_0000_0000_0000;

    // How the first-quadrant angle is obtained.
    typedef enum logic [1:0] {
        PHI_ZERO,
        PHI_QUARTER,
        PHI_EIGHTH,
        PHI_CORDIC
    } phi_kind_t;

    // Control that travels alongside each vector.
    typedef struct packed {
        logic      x_neg;
        logic      y_neg;
        logic      swapped;
        phi_kind_t kind;
    } vaq_tag_t;

    // Long division for table construction only.
    function automatic logic [ACC_W-1:0] udiv64(input logic [ACC_W-1:0] num,
                                                input logic [ACC_W-1:0] den);
        logic [ACC_W-1:0] quo;
        logic [ACC_W-1:0] rem;
        int               k;
        quo = '0;
        rem = '0;
        for (k = ACC_W - 1; k >= 0; k--) begin
            rem = {rem[ACC_W-2:0], num[k]};
            quo = {quo[ACC_W-2:0], 1'b0};
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Truncated arctangent series in Q61; each power is (p / div) >> sh and each term is that power / (2n + 1).
    function automatic logic [ACC_W-1:0] atan_series(input logic [ACC_W-1:0] p0,
                                                     input logic [ACC_W-1:0] div,
                                                     input int unsigned sh);
        logic [ACC_W-1:0] p;
        logic [ACC_W-1:0] sum;
        logic [ACC_W-1:0] term;
        logic [ACC_W-1:0] n;
        logic             neg;
        logic             done;
        int               t;
        p    = p0;
        sum  = p0;
        n    = 64'd1;
        neg  = 1'b1;
        done = 1'b0;
        for (t = 0; t < ACC_W; t++) begin
            if (!done) begin
                p = udiv64(p, div);
                p = (sh >= 64) ? '0 : (p >> sh);
                if (p == '0) begin
                    done = 1'b1;
                end else begin
                    term = udiv64(p, (n << 1) + 64'd1);
                    sum  = neg ? (sum - term) : (sum + term);
                    neg  = !neg;
                    n    = n + 64'd1;
                end
            end
        end
        return sum;
    endfunction

    // floor(a * 2^64 / b) for a < b < 2^63.
    function automatic logic [ACC_W-1:0] frac_div(input logic [ACC_W-1:0] a_in,
                                                  input logic [ACC_W-1:0] b);
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] q;
        int               k;
        a = a_in;
        q = '0;
        for (k = 0; k < ACC_W; k++) begin
            a = a << 1;
            q = q << 1;
            if (a >= b) begin
                a    = a - b;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Pi in Q61 by Machin's formula.
    localparam logic [ACC_W-1:0] PI_Q =
        64'd16 * atan_series(Q61_ONE / 64'd5, 64'd25, 0)
        - 64'd4 * atan_series(Q61_ONE / 64'd239, 64'd57121, 0);

    // Rotation angle of CORDIC step i, in turns.
    function automatic logic [ACC_W-1:0] turn_step(input int i);
        logic [ACC_W-1:0] res;
        if (i == 0) begin
            res = TURN_EIGHTH;
        end else begin
            res = frac_div(atan_series(Q61_ONE >> i, 64'd1, 2 * i), PI_Q) >> 1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vaq_prep.sv =====
// -----------------------------------------------------------------------------
// Vector angle quantizer front end
// Folds the vector into the first octant and normalises it for the CORDIC.
// -----------------------------------------------------------------------------
`default_nettype none
`include "vector_angle_quantizer_defines.svh"

module vaq_prep (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    en,
    input  wire                                    in_valid,
    input  wire signed [vaq_pkg::COORD_BITS-1:0]   in_x,
    input  wire signed [vaq_pkg::COORD_BITS-1:0]   in_y,
    output logic                                   out_valid,
    output vaq_pkg::vaq_tag_t                      out_tag,
    output logic signed [vaq_pkg::ACC_W-1:0]       out_big,
    output logic signed [vaq_pkg::ACC_W-1:0]       out_small
);
    import vaq_pkg::*;

    // Stage one: magnitudes, octant fold and special directions.
    logic              s1_v_reg;
    vaq_tag_t          s1_tag_reg, s1_tag_next;
    logic [MAG_W-1:0]  s1_big_reg, s1_big_next;
    logic [MAG_W-1:0]  s1_small_reg, s1_small_next;
    logic [MAG_W-1:0]  ax, ay;

    // Stage two: leading one position of the larger magnitude.
    logic              s2_v_reg;
    vaq_tag_t          s2_tag_reg;
    logic [MAG_W-1:0]  s2_big_reg, s2_small_reg;
    logic [MSB_W-1:0]  s2_msb_reg, s2_msb_next;

    // Stage three: normalised operands.
    logic              s3_v_reg;
    vaq_tag_t          s3_tag_reg;
    logic [ACC_W-1:0]  s3_big_reg, s3_big_next;
    logic [ACC_W-1:0]  s3_small_reg, s3_small_next;
    logic [SH_W-1:0]   shamt;

    // The most negative input maps onto the top magnitude bit without loss.
    assign ax = in_x[COORD_BITS-1] ? MAG_W'(~in_x + 1'b1) : MAG_W'(in_x);
    assign ay = in_y[COORD_BITS-1] ? MAG_W'(~in_y + 1'b1) : MAG_W'(in_y);

    always_comb begin
        s1_tag_next.x_neg   = in_x[COORD_BITS-1];
        s1_tag_next.y_neg   = in_y[COORD_BITS-1];
        s1_tag_next.swapped = (ay > ax);
        if (ay == '0) begin
            // The zero vector points along the positive y axis.
            s1_tag_next.kind = (ax == '0) ? PHI_QUARTER : PHI_ZERO;
        end else if (ax == '0) begin
            s1_tag_next.kind = PHI_QUARTER;
        end else if (ax == ay) begin
            s1_tag_next.kind = PHI_EIGHTH;
        end else begin
            s1_tag_next.kind = PHI_CORDIC;
        end
        s1_big_next   = (ay > ax) ? ay : ax;
        s1_small_next = (ay > ax) ? ax : ay;
    end

    // Priority encoder over the larger magnitude.
    always_comb begin
        s2_msb_next = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (s1_big_reg[b]) begin
                s2_msb_next = MSB_W'(b);
            end
        end
    end

    // Shift so that the larger magnitude has its leading one at NORM_MSB.
    assign shamt         = SH_W'(NORM_MSB) - SH_W'(s2_msb_reg);
    assign s3_big_next   = ACC_W'(s2_big_reg) << shamt;
    assign s3_small_next = ACC_W'(s2_small_reg) << shamt;

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else if (en) begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tag_reg   <= s1_tag_next;
            s1_big_reg   <= s1_big_next;
            s1_small_reg <= s1_small_next;
            s2_tag_reg   <= s1_tag_reg;
            s2_big_reg   <= s1_big_reg;
            s2_small_reg <= s1_small_reg;
            s2_msb_reg   <= s2_msb_next;
            s3_tag_reg   <= s2_tag_reg;
            s3_big_reg   <= s3_big_next;
            s3_small_reg <= s3_small_next;
        end
    end

    assign out_valid = s3_v_reg;
    assign out_tag   = s3_tag_reg;
    assign out_big   = signed'(s3_big_reg);
    assign out_small = signed'(s3_small_reg);

    // A vector headed for the CORDIC is normalised and strictly inside the octant.
    `VAQ_ASSERT_IMP(a_prep_norm, s3_v_reg && (s3_tag_reg.kind == PHI_CORDIC), s3_big_reg[NORM_MSB] && (s3_big_reg[ACC_W-1:NORM_MSB+1] == '0) && (s3_small_reg < s3_big_reg), "CORDIC operand not normalised")

endmodule

`default_nettype wire

// ===== rtl/core/vaq_cordic.sv =====
// -----------------------------------------------------------------------------
// Vector angle quantizer CORDIC pipeline
// Vectoring CORDIC, one rotation per register stage, angle kept in turns.
// -----------------------------------------------------------------------------
`default_nettype none
`include "vector_angle_quantizer_defines.svh"

module vaq_cordic (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    en,
    input  wire                                    in_valid,
    input  wire vaq_pkg::vaq_tag_t                 in_tag,
    input  wire signed [vaq_pkg::ACC_W-1:0]        in_x,
    input  wire signed [vaq_pkg::ACC_W-1:0]        in_y,
    output logic                                   out_valid,
    output vaq_pkg::vaq_tag_t                      out_tag,
    output logic [vaq_pkg::ACC_W-1:0]              out_z
);
    import vaq_pkg::*;

    // Stage registers, one entry per rotation.
    logic                    v_reg   [CORDIC_ITERS];
    vaq_tag_t                tag_reg [CORDIC_ITERS];
    logic signed [ACC_W-1:0] x_reg   [CORDIC_ITERS];
    logic signed [ACC_W-1:0] y_reg   [CORDIC_ITERS];
    logic [ACC_W-1:0]        z_reg   [CORDIC_ITERS];

    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_stage
        localparam logic [ACC_W-1:0] STEP = turn_step(g);

        logic                    v_in;
        vaq_tag_t                tag_in;
        logic signed [ACC_W-1:0] x_in, y_in;
        logic [ACC_W-1:0]        z_in;
        logic signed [ACC_W-1:0] x_next, y_next;
        logic [ACC_W-1:0]        z_next;

        // Stage input: from the front end or from the previous rotation.
        if (g == 0) begin : g_head
            assign v_in   = in_valid;
            assign tag_in = in_tag;
            assign x_in   = in_x;
            assign y_in   = in_y;
            assign z_in   = '0;
        end else begin : g_body
            assign v_in   = v_reg[g-1];
            assign tag_in = tag_reg[g-1];
            assign x_in   = x_reg[g-1];
            assign y_in   = y_reg[g-1];
            assign z_in   = z_reg[g-1];
        end

        // Rotate towards the x axis and accumulate the rotation angle.
        always_comb begin
            if (!y_in[ACC_W-1]) begin
                x_next = x_in + (y_in >>> g);
                y_next = y_in - (x_in >>> g);
                z_next = z_in + STEP;
            end else begin
                x_next = x_in - (y_in >>> g);
                y_next = y_in + (x_in >>> g);
                z_next = z_in - STEP;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[g] <= tag_in;
                x_reg[g]   <= x_next;
                y_reg[g]   <= y_next;
                z_reg[g]   <= z_next;
            end
        end
    end

    assign out_valid = v_reg[CORDIC_ITERS-1];
    assign out_tag   = tag_reg[CORDIC_ITERS-1];
    assign out_z     = z_reg[CORDIC_ITERS-1];

    // The x component only grows for a vector inside the first octant.
    `VAQ_ASSERT_IMP(a_cordic_x_pos, v_reg[CORDIC_ITERS-1] && (tag_reg[CORDIC_ITERS-1].kind == PHI_CORDIC), x_reg[CORDIC_ITERS-1] > 0, "CORDIC x went non-positive")

endmodule

`default_nettype wire

// ===== rtl/core/vaq_post.sv =====
// -----------------------------------------------------------------------------
// Vector angle quantizer back end
// Unfolds the octant angle to a full turn, rounds and masks the code.
// -----------------------------------------------------------------------------
`default_nettype none
`include "vector_angle_quantizer_defines.svh"

module vaq_post (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    en,
    input  wire                                    in_valid,
    input  wire vaq_pkg::vaq_tag_t                 in_tag,
    input  wire [vaq_pkg::ACC_W-1:0]               in_z,
    input  wire [vaq_pkg::ABITS_W-1:0]             angle_bits,
    input  wire [vaq_pkg::OBYTES_W-1:0]            output_bytes,
    output logic                                   out_valid,
    output logic [vaq_pkg::CODE_W-1:0]             out_code
);
    import vaq_pkg::*;

    logic             p1_v_reg, p2_v_reg, p3_v_reg, out_v_reg;
    logic             p1_xn_reg, p1_yn_reg;
    logic [ACC_W-1:0] p1_phi_reg, p1_phi_next;
    logic [ACC_W-1:0] p2_a_reg, p2_a_next;
    logic [ACC_W-1:0] p3_sum_reg, p3_sum_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [ACC_W-1:0] round_bit;
    logic [ACC_W-1:0] shifted;

    // First-quadrant angle.
    always_comb begin
        case (in_tag.kind)
            PHI_ZERO:    p1_phi_next = '0;
            PHI_QUARTER: p1_phi_next = TURN_QUARTER;
            PHI_EIGHTH:  p1_phi_next = TURN_EIGHTH;
            PHI_CORDIC:  p1_phi_next = in_tag.swapped ? (TURN_QUARTER - in_z) : in_z;
            default:     p1_phi_next = '0;
        endcase
    end

    // Place the angle in its quadrant; the sum wraps modulo one turn.
    always_comb begin
        if (!p1_xn_reg && !p1_yn_reg) begin
            p2_a_next = p1_phi_reg;
        end else if (p1_xn_reg && !p1_yn_reg) begin
            p2_a_next = TURN_HALF - p1_phi_reg;
        end else if (p1_xn_reg) begin
            p2_a_next = TURN_HALF + p1_phi_reg;
        end else begin
            p2_a_next = '0 - p1_phi_reg;
        end
    end

    // Add half a step so that the truncation below rounds ties upwards.
    assign round_bit   = (angle_bits == '0) ? '0 :
                         (ACC_W'(1) << (SH_W'(ACC_W - 1) - SH_W'(angle_bits)));
    assign p3_sum_next = p2_a_reg + round_bit;

    // Keep the top angle_bits bits, then mask to the output width.
    assign shifted = p3_sum_reg >> (7'(ACC_W) - 7'(angle_bits));
    always_comb begin
        if (angle_bits == '0) begin
            code_next = '0;
        end else if (output_bytes == OBYTES_ONE) begin
            code_next = {8'h00, shifted[7:0]};
        end else begin
            code_next = shifted[CODE_W-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            p1_v_reg  <= in_valid;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            out_v_reg <= p3_v_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_xn_reg  <= in_tag.x_neg;
            p1_yn_reg  <= in_tag.y_neg;
            p1_phi_reg <= p1_phi_next;
            p2_a_reg   <= p2_a_next;
            p3_sum_reg <= p3_sum_next;
            code_reg   <= code_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_code  = code_reg;

    // Zero angle bits always give a zero code.
    `VAQ_ASSERT_NXT(a_post_zero_bits, en && (angle_bits == '0), code_reg == '0, "non-zero code with zero angle bits")
    // One-byte output leaves the upper byte clear.
    `VAQ_ASSERT_NXT(a_post_byte_mask, en && (output_bytes == OBYTES_ONE), code_reg[CODE_W-1:8] == '0, "upper byte set in one-byte mode")

endmodule

`default_nettype wire

// ===== rtl/core/vector_angle_quantizer.sv =====
// -----------------------------------------------------------------------------
// Vector angle quantizer
// Gives the direction of a signed vector as a rounded angle code.
// -----------------------------------------------------------------------------
//  Channel   Direction  Payload (lowest bit first)
//  s_*       in         tdata: vec_x[15:0], vec_y[31:16]
//  m_*       out        tdata: angle_code[15:0]
//  cfg_*     in         index 0 angle_bits, index 1 output_bytes
//
//  One transaction per cycle is accepted while the output is not stalled;
//  the pipeline holds 62 CORDIC stages, three front-end and four back-end stages.
//  Reset clears the valid bits and angle_bits, sets output_bytes to 2; there is no clearing pass.
//  A stall at the output freezes the whole pipeline; s_tready follows it.
// -----------------------------------------------------------------------------
`default_nettype none

module vector_angle_quantizer (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // Input stream
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [31:0]                          s_tdata,   // vec_x[15:0], vec_y[31:16]
    // Result stream
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [15:0]                         m_tdata,   // angle_code[15:0]
    // Configuration writes
    input  wire                                 cfg_wr_en,
    input  wire [vaq_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire [vaq_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);
    import vaq_pkg::*;

    logic                      en;
    logic signed [COORD_BITS-1:0] vec_x, vec_y;
    logic [ABITS_W-1:0]        angle_bits_reg;
    logic [OBYTES_W-1:0]       output_bytes_reg;

    logic                      pre_valid;
    vaq_tag_t                  pre_tag;
    logic signed [ACC_W-1:0]   pre_big, pre_small;
    logic                      cor_valid;
    vaq_tag_t                  cor_tag;
    logic [ACC_W-1:0]          cor_z;

    // Pipeline advances whenever the output register is free or being drained.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign vec_x = signed'(s_tdata[COORD_BITS-1:0]);
    assign vec_y = signed'(s_tdata[2*COORD_BITS-1:COORD_BITS]);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_bits_reg   <= '0;
            output_bytes_reg <= OBYTES_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_ANGLE_BITS:   angle_bits_reg   <= cfg_wr_data[ABITS_W-1:0];
                CFG_OUTPUT_BYTES: output_bytes_reg <= cfg_wr_data[OBYTES_W-1:0];
                default: ;
            endcase
        end
    end

    vaq_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_x      (vec_x),
        .in_y      (vec_y),
        .out_valid (pre_valid),
        .out_tag   (pre_tag),
        .out_big   (pre_big),
        .out_small (pre_small)
    );

    vaq_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pre_valid),
        .in_tag    (pre_tag),
        .in_x      (pre_big),
        .in_y      (pre_small),
        .out_valid (cor_valid),
        .out_tag   (cor_tag),
        .out_z     (cor_z)
    );

    vaq_post u_post (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (cor_valid),
        .in_tag       (cor_tag),
        .in_z         (cor_z),
        .angle_bits   (angle_bits_reg),
        .output_bytes (output_bytes_reg),
        .out_valid    (m_tvalid),
        .out_code     (m_tdata)
    );

endmodule

`default_nettype wire
